>>> design/kcle_pkg.sv
// Package for the keypad code-line entry block.
// Holds the item and result types, the function codes and the key character ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcle_pkg;

    localparam int LINE_DEPTH = 16;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int CHAR_W     = 7;
    localparam int CODE_W     = 6;
    localparam int LEN_W      = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [IDX_W-1:0]  MAX_LEN    = IDX_W'(LINE_DEPTH - 1);
    localparam logic [CHAR_W-1:0] ENTER_CHAR = 7'h2a;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 7'h00;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0]        func;
        logic              data_available;
        logic [CODE_W-1:0] key_code;
        logic [3:0]        read_index;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [LEN_W-1:0]  line_length;
        logic              enter_seen;
        logic              key_read_strobe;
        logic [CHAR_W-1:0] key_char;
    } result_t;

    function automatic logic [CHAR_W-1:0] decode_key(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            6'd0:    c = 7'h41; // A
            6'd1:    c = 7'h42; // B
            6'd2:    c = 7'h43; // C
            6'd3:    c = 7'h45; // E
            6'd4:    c = 7'h47; // G
            6'd5:    c = 7'h48; // H
            6'd6:    c = 7'h49; // I
            6'd7:    c = 7'h4a; // J
            6'd8:    c = 7'h4d; // M
            6'd9:    c = 7'h4e; // N
            6'd10:   c = 7'h4f; // O
            6'd11:   c = 7'h50; // P
            6'd12:   c = 7'h51; // Q
            6'd13:   c = 7'h52; // R
            6'd14:   c = 7'h53; // S
            6'd15:   c = 7'h54; // T
            6'd16:   c = 7'h56; // V
            6'd17:   c = 7'h58; // X
            6'd18:   c = 7'h59; // Y
            6'd19:   c = 7'h5a; // Z
            6'd32:   c = 7'h4c; // L
            6'd33:   c = 7'h2d; // -
            6'd34:   c = 7'h2b; // +
            6'd35:   c = 7'h46; // F
            6'd36:   c = 7'h37; // 7
            6'd37:   c = 7'h38; // 8
            6'd38:   c = 7'h39; // 9
            6'd39:   c = 7'h23; // #
            6'd40:   c = 7'h34; // 4
            6'd41:   c = 7'h35; // 5
            6'd42:   c = 7'h36; // 6
            6'd43:   c = 7'h55; // U
            6'd44:   c = 7'h31; // 1
            6'd45:   c = 7'h32; // 2
            6'd46:   c = 7'h33; // 3
            6'd47:   c = 7'h44; // D
            6'd48:   c = 7'h30; // 0
            6'd49:   c = 7'h2f; // /
            6'd50:   c = 7'h2e; // .
            6'd51:   c = ENTER_CHAR;
            default: c = NUL_CHAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/kcle_line_store.sv
// Line store and key decode for the keypad code-line entry block.
// Holds the edge detector, character store and count; forms one result per item.
// Depends on kcle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcle_line_store (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_en,
    input  wire kcle_pkg::item_t item,
    output kcle_pkg::result_t    result
);
    import kcle_pkg::*;

    logic                  prev_avail_reg, prev_avail_next;
    logic                  cur_avail_reg, cur_avail_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic [CHAR_W-1:0]     chars_reg [LINE_DEPTH];
    logic [CHAR_W-1:0]     chars_next [LINE_DEPTH];

    logic                  is_tick, is_read, is_clear;
    logic                  rise;
    logic [CHAR_W-1:0]     key;
    logic                  enter;
    logic                  append;
    logic [IDX_W-1:0]      term_idx;
    logic [CHAR_W-1:0]     rd_char;

    assign is_tick  = item.func == FUNC_TICK;
    assign is_read  = item.func == FUNC_READ;
    assign is_clear = item.func == FUNC_CLEAR;
    assign rise     = is_tick && item.data_available && !cur_avail_reg;
    assign key      = rise ? decode_key(item.key_code) : NUL_CHAR;
    assign enter    = key == ENTER_CHAR;
    assign append   = !enter && key != NUL_CHAR && count_reg < MAX_LEN;
    assign term_idx = IDX_W'(count_reg + 1'b1);

    always_comb begin
        prev_avail_next = prev_avail_reg;
        cur_avail_next  = cur_avail_reg;
        count_next      = count_reg;
        if (is_tick) begin
            prev_avail_next = cur_avail_reg;
            cur_avail_next  = item.data_available;
            if (enter) begin
                count_next = '0;
            end else if (append) begin
                count_next = IDX_W'(count_reg + 1'b1);
            end
        end else if (is_clear) begin
            count_next = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            chars_next[i] = chars_reg[i];
            if (is_tick && append && count_reg == IDX_W'(i)) begin
                chars_next[i] = key;
            end
            if (is_tick && append && term_idx == IDX_W'(i)) begin
                chars_next[i] = NUL_CHAR;
            end
            if (is_clear && i == 0) begin
                chars_next[i] = NUL_CHAR;
            end
        end
    end

    always_comb begin
        rd_char = NUL_CHAR;
        if (is_read && count_reg == '0) begin
            rd_char = chars_reg[item.read_index[IDX_W-1:0]];
        end
    end

    assign result.key_char        = key;
    assign result.key_read_strobe = rise;
    assign result.enter_seen      = enter;
    assign result.line_length     = LEN_W'(count_next);
    assign result.read_char       = rd_char;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_avail_reg <= 1'b0;
            cur_avail_reg  <= 1'b0;
            count_reg      <= '0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                chars_reg[i] <= NUL_CHAR;
            end
        end else if (item_en) begin
            prev_avail_reg <= prev_avail_next;
            cur_avail_reg  <= cur_avail_next;
            count_reg      <= count_next;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                chars_reg[i] <= chars_next[i];
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_LEN)
        else $error("line count past store depth");

    a_enter_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en && enter |=> count_reg == '0)
        else $error("enter key did not close the line");

    a_strobe_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        result.key_read_strobe |-> is_tick && !prev_avail_next)
        else $error("key read without a rising edge");

    a_read_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        result.read_char != NUL_CHAR |-> is_read && count_reg == '0)
        else $error("line character returned while line open");

endmodule

`default_nettype wire

>>> design/kcle_out_reg.sv
// Result register of the keypad code-line entry block.
// Holds one result beat toward the master side and reports when it can take another.
// Depends on kcle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kcle_out_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load_valid,
    output logic               load_ready,
    input  wire kcle_pkg::result_t load_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [kcle_pkg::OUT_DATA_W-1:0] m_tdata // key_char, key_read_strobe,
                                                    // enter_seen, line_length, read_char
);
    import kcle_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign load_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_valid && load_ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_DATA_W'(data_reg);

endmodule

`default_nettype wire

>>> design/keypad_code_line_entry.sv
// Keypad code-line entry: edge-detected key decode into a short character line.
// Input beats carry a tick sample, a line read or a line clear; each gives one result beat.
// An item passes an input register, then the store logic, then a result register.
// Throughput is one beat per cycle while the receiver takes every result beat; the
// store and count update in the cycle an item moves from the input register into
// the result register.
// While the receiver stalls, the result register holds its beat and the input
// register holds one more item; s_tready drops only when both are full.
// Reset clears the edge detector, the line count and all 16 stored characters,
// and empties both registers.
// Depends on kcle_pkg, kcle_line_store and kcle_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_line_entry (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [kcle_pkg::IN_DATA_W-1:0] s_tdata, // data_available, key_code,
                                                         // read_index
    input  wire logic [1:0]  s_tuser,                    // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [kcle_pkg::OUT_DATA_W-1:0] m_tdata      // key_char, key_read_strobe,
                                                         // enter_seen, line_length,
                                                         // read_char
);
    import kcle_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    item_t   item_in;
    result_t result;
    logic    out_ready;
    logic    advance;
    logic    s_beat;

    assign item_in.func           = s_tuser;
    assign item_in.data_available = s_tdata[0];
    assign item_in.key_code       = s_tdata[6:1];
    assign item_in.read_index     = s_tdata[10:7];

    assign advance  = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            item_reg <= item_in;
        end
    end

    kcle_line_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .item    (item_reg),
        .result  (result)
    );

    kcle_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_ready (out_ready),
        .load_data  (result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

>>> bench/keypad_code_line_entry_test.sv
// Self-checking bench for keypad_code_line_entry: directed table, then random typed lines.
// Expected beats come from a line-entry predictor or typed rows; depends on kcle_pkg.
`timescale 1ns / 1ps

module keypad_code_line_entry_test;
    import kcle_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         RAND_BEATS  = 900;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         STALL_LEN   = 300;
    localparam int         STALL_AFTER = 150;

    // one planned input beat; typed rows carry a hand-written expected result
    typedef struct packed {
        logic [1:0]        func;
        logic              da;
        logic [CODE_W-1:0] code;
        logic [3:0]        idx;
        logic              typed;
        logic [CHAR_W-1:0] key_char;
        logic              strobe;
        logic              enter;
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] rchar;
    } key_beat_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = FUNC_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    keypad_code_line_entry dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // func, da, code, idx, typed, key_char, strobe, enter, len, read_char
    key_beat_t key_table [24] = '{
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b1, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_READ,  1'b0, 6'd0,  4'd0,  1'b1, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd0,  4'd0,  1'b1, 7'h41, 1'b1, 1'b0, 4'd1, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd63, 4'd15, 1'b1, 7'h00, 1'b0, 1'b0, 4'd1, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd63, 4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd63, 4'd0,  1'b1, 7'h00, 1'b1, 1'b0, 4'd1, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd52, 4'd0,  1'b1, 7'h00, 1'b1, 1'b0, 4'd1, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd20, 4'd0,  1'b1, 7'h00, 1'b1, 1'b0, 4'd1, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd19, 4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_READ,  1'b0, 6'd0,  4'd0,  1'b1, 7'h00, 1'b0, 1'b0, 4'd2, 7'h00},
        '{FUNC_SPARE, 1'b1, 6'd51, 4'd15, 1'b1, 7'h00, 1'b0, 1'b0, 4'd2, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd51, 4'd0,  1'b1, 7'h2a, 1'b1, 1'b1, 4'd0, 7'h00},
        '{FUNC_READ,  1'b1, 6'd63, 4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_READ,  1'b0, 6'd0,  4'd1,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_READ,  1'b0, 6'd0,  4'd15, 1'b1, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b1, 6'd48, 4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_CLEAR, 1'b1, 6'd51, 4'd15, 1'b1, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_READ,  1'b0, 6'd0,  4'd1,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00},
        '{FUNC_TICK,  1'b0, 6'd0,  4'd0,  1'b0, 7'h00, 1'b0, 1'b0, 4'd0, 7'h00}
    };

    key_beat_t key_plan [$];
    result_t   pending_results [$];

    // character map: codes 0..19 and 32..51, everything else is NUL
    string letter_keys = "ABCEGHIJMNOPQRSTVXYZ";
    string symbol_keys = "L-+F789#456U123D0/.*";

    // predictor state
    logic              avail_prev = 1'b0;
    logic              avail_now  = 1'b0;
    logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
    logic [LEN_W-1:0]  line_len   = '0;

    int in_beats    = 0;
    int out_beats   = 0;
    int err_cnt     = 0;
    int idle_cycles = 0;
    int enter_cnt   = 0;
    int full_cnt    = 0;
    int tx_burst    = 0;
    int rx_burst    = 0;
    bit stall_done  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [CHAR_W-1:0] char_of_code(input logic [CODE_W-1:0] code);
        if (code < 6'd20)
            return CHAR_W'(letter_keys[int'(code)]);
        if (code >= 6'd32 && code < 6'd52)
            return CHAR_W'(symbol_keys[int'(code) - 32]);
        return NUL_CHAR;
    endfunction

    function automatic result_t step_line_entry(input key_beat_t b);
        result_t r;
        r = '0;
        case (b.func)
            FUNC_TICK: begin
                avail_prev = avail_now;
                avail_now  = b.da;
                if (avail_now && !avail_prev) begin
                    r.key_read_strobe = 1'b1;
                    r.key_char        = char_of_code(b.code);
                end
                if (r.key_char == ENTER_CHAR) begin
                    r.enter_seen = 1'b1;
                    line_len     = '0;
                end else if (r.key_char != NUL_CHAR && line_len < MAX_LEN) begin
                    line_buf[line_len] = r.key_char;
                    line_len           = line_len + 1'b1;
                    line_buf[line_len] = NUL_CHAR;
                end
            end
            FUNC_READ: begin
                if (line_len == '0)
                    r.read_char = line_buf[b.idx];
            end
            FUNC_CLEAR: begin
                line_len    = '0;
                line_buf[0] = NUL_CHAR;
            end
            default: ;
        endcase
        r.line_length = line_len;
        return r;
    endfunction

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CODE_W-1:0] pick_key_code();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            v = $urandom_range(0, 38);
            return (v < 20) ? CODE_W'(v) : CODE_W'(v + 12);
        end
        if (r < 90)
            return 6'd51;
        if (r < 95)
            return CODE_W'($urandom_range(20, 31));
        return CODE_W'($urandom_range(52, 63));
    endfunction

    task automatic plan_beat(input logic [1:0] func, input logic da,
                             input logic [CODE_W-1:0] code, input logic [3:0] idx);
        key_beat_t b;
        b       = '0;
        b.func  = func;
        b.da    = da;
        b.code  = code;
        b.idx   = idx;
        key_plan.push_back(b);
    endtask

    task automatic plan_random_beats();
        int r;
        int n;
        while (key_plan.size() < $size(key_table) + RAND_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                // a typed line: release, press, sometimes held, usually ended by '*'
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 8);
                repeat (n) begin
                    repeat ($urandom_range(1, 2))
                        plan_beat(FUNC_TICK, 1'b0, CODE_W'($urandom), 4'($urandom));
                    plan_beat(FUNC_TICK, 1'b1, pick_key_code(), 4'($urandom));
                    if ($urandom_range(0, 9) < 3)
                        plan_beat(FUNC_TICK, 1'b1, CODE_W'($urandom), 4'($urandom));
                end
                if ($urandom_range(0, 9) < 8) begin
                    plan_beat(FUNC_TICK, 1'b0, CODE_W'($urandom), 4'($urandom));
                    plan_beat(FUNC_TICK, 1'b1, 6'd51, 4'($urandom));
                end
                repeat ($urandom_range(0, 4))
                    plan_beat(FUNC_READ, 1'($urandom), CODE_W'($urandom), 4'($urandom));
                if ($urandom_range(0, 99) < 15)
                    plan_beat(FUNC_CLEAR, 1'($urandom), CODE_W'($urandom), 4'($urandom));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 6))
                    plan_beat(2'($urandom_range(0, 3)), 1'($urandom), CODE_W'($urandom),
                              4'($urandom));
            end else begin
                plan_beat(FUNC_CLEAR, 1'($urandom), CODE_W'($urandom), 4'($urandom));
                repeat ($urandom_range(1, 4))
                    plan_beat(FUNC_READ, 1'($urandom), CODE_W'($urandom), 4'($urandom));
            end
        end
    endtask

    // sender
    initial begin
        int gap;
        foreach (line_buf[i])
            line_buf[i] = NUL_CHAR;
        foreach (key_table[i])
            key_plan.push_back(key_table[i]);
        plan_random_beats();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < key_plan.size(); i++) begin
            gap = pick_gap(tx_burst);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= key_plan[i].func;
            s_tdata  <= {5'b0, key_plan[i].idx, key_plan[i].code, key_plan[i].da};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
        while (in_beats < key_plan.size() || pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Ran %0d input beats and %0d result beats, %0d mismatches.",
                 in_beats, out_beats, err_cnt);
        $display("Lines ended by enter: %0d, keys dropped on a full line: %0d.",
                 enter_cnt, full_cnt);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver, with one long hold-off once traffic is flowing
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!stall_done && out_beats >= STALL_AFTER) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
            end
            gap = pick_gap(rx_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // monitors: input side first, so a beat's expectation is queued before its result
    always @(posedge aclk) begin
        key_beat_t b;
        result_t   want;
        result_t   got;
        if (aresetn && s_tvalid && s_tready) begin
            b = key_plan[in_beats];
            if (b.func == FUNC_TICK && avail_now == 1'b0 && b.da &&
                char_of_code(b.code) != NUL_CHAR && char_of_code(b.code) != ENTER_CHAR &&
                line_len == MAX_LEN)
                full_cnt++;
            want = step_line_entry(b);
            if (want.enter_seen)
                enter_cnt++;
            if (b.typed)
                want = '{read_char: b.rchar, line_length: b.len, enter_seen: b.enter,
                         key_read_strobe: b.strobe, key_char: b.key_char};
            pending_results.push_back(want);
            in_beats++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: result beat %0d with nothing expected, got %h",
                         $time, out_beats, got);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: result beat %0d mismatch: expected key %h strobe %b enter %b len %0d rd %h, got key %h strobe %b enter %b len %0d rd %h",
                             $time, out_beats, want.key_char, want.key_read_strobe,
                             want.enter_seen, want.line_length, want.read_char,
                             got.key_char, got.key_read_strobe, got.enter_seen,
                             got.line_length, got.read_char);
                    err_cnt++;
                end
            end
            out_beats++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

>>> filelist.f
design/kcle_pkg.sv
design/kcle_line_store.sv
design/kcle_out_reg.sv
design/keypad_code_line_entry.sv
bench/keypad_code_line_entry_test.sv
